@@ rtl/upn_pkg.sv @@
`default_nettype none
package upn_pkg;

  localparam int PREFIX_MAX_DEF = 48;
  localparam int PREFIX_WORDS   = 6;
  localparam int PREFIX_BYTES   = 8 * PREFIX_WORDS;
  localparam int QUEUE_DEPTH    = 4;
  localparam int BUNDLE_BYTES   = 4;
  localparam int CFG_AW         = 6;
  localparam int CFG_DW         = 64;

  localparam logic [2:0] REG_PREFIX_LENGTH = 3'd0;
  localparam logic [2:0] REG_PREFIX_WORD_0 = 3'd1;
  localparam logic [2:0] REG_PREFIX_WORD_5 = 3'd6;

  typedef enum logic [2:0] {
    PH_PREFIX = 3'd0,
    PH_PATH   = 3'd1,
    PH_QUERY  = 3'd2,
    PH_REJECT = 3'd3
  } phase_t;

  typedef struct packed {
    logic [5:0]                        prefix_length;
    logic [PREFIX_WORDS-1:0][63:0]     prefix_words;
  } cfg_t;

  typedef struct packed {
    logic [2:0]                        nbytes;
    logic [BUNDLE_BYTES-1:0][7:0]      bytes;
    logic                              has_end;
    logic                              rejected;
  } bundle_t;

endpackage
`default_nettype wire

@@ rtl/upn_cfg.sv @@
`default_nettype none
module upn_cfg import upn_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg
);

  logic [5:0]                    prefix_length_r;
  logic [PREFIX_WORDS-1:0][63:0] prefix_words_r;
  logic [2:0]                    idx;
  logic [2:0]                    widx;
  logic                          wr;

  assign idx    = paddr[5:3];
  assign widx   = idx - REG_PREFIX_WORD_0;
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prefix_length_r <= '0;
      prefix_words_r  <= '0;
    end else if (wr) begin
      if (idx == REG_PREFIX_LENGTH) begin
        prefix_length_r <= pwdata[5:0];
      end else if (idx >= REG_PREFIX_WORD_0 && idx <= REG_PREFIX_WORD_5) begin
        prefix_words_r[widx] <= pwdata;
      end
    end
  end

  always_comb begin
    prdata = '0;
    if (idx == REG_PREFIX_LENGTH) begin
      prdata = {58'd0, prefix_length_r};
    end else if (idx >= REG_PREFIX_WORD_0 && idx <= REG_PREFIX_WORD_5) begin
      prdata = prefix_words_r[widx];
    end
  end

  assign cfg.prefix_length = prefix_length_r;
  assign cfg.prefix_words  = prefix_words_r;

endmodule
`default_nettype wire

@@ rtl/upn_front.sv @@
`default_nettype none
module upn_front import upn_pkg::*; #(
  parameter int PREFIX_MAX = PREFIX_MAX_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  cfg_t       cfg,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_url_byte,
  input  logic       in_byte_present,
  input  logic       in_final_byte,
  input  logic       q_full,
  output logic       push,
  output bundle_t    push_data
);

  localparam logic [5:0] PMAX    = 6'(PREFIX_MAX);
  localparam logic [7:0] C_SLASH = 8'h2F;
  localparam logic [7:0] C_DOT   = 8'h2E;
  localparam logic [7:0] C_PCT   = 8'h25;
  localparam logic [7:0] C_QMARK = 8'h3F;
  localparam logic [7:0] C_BSL   = 8'h5C;
  localparam logic [7:0] C_DEL   = 8'h7F;
  localparam logic [7:0] C_SPACE = 8'h20;

  function automatic logic is_bad(input logic [7:0] c);
    return c == C_BSL || c < C_SPACE || c == C_DEL;
  endfunction

  function automatic logic hex_ok(input logic [7:0] c);
    return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h66) ||
           (c >= 8'h41 && c <= 8'h46);
  endfunction

  function automatic logic [3:0] hex_val(input logic [7:0] c);
    logic [7:0] v;
    v = 8'h00;
    if (c >= 8'h30 && c <= 8'h39) v = c - 8'h30;
    else if (c >= 8'h61 && c <= 8'h66) v = c - 8'h57;
    else if (c >= 8'h41 && c <= 8'h46) v = c - 8'h37;
    return v[3:0];
  endfunction

  phase_t     phase_r, phase_nxt;
  logic [5:0] pos_r, pos_nxt;
  logic [1:0] pds_r, pds_nxt;
  logic [3:0] phn_r, phn_nxt;
  logic [1:0] slen_r, slen_nxt;
  logic [7:0] held0_r, held0_nxt;
  logic [7:0] held1_r, held1_nxt;
  logic       started_r, started_nxt;

  logic [PREFIX_BYTES-1:0][7:0] pbytes;
  logic [5:0]                   eff_len;
  logic [7:0]                   want;
  logic                         accept;

  phase_t                       ph;
  logic [5:0]                   pos;
  logic [1:0]                   pds;
  logic [3:0]                   phn;
  logic [1:0]                   slen;
  logic [7:0]                   h0;
  logic [7:0]                   h1;
  logic                         st;
  logic [2:0]                   nb;
  logic [BUNDLE_BYTES-1:0][7:0] bb;
  logic                         dec_v;
  logic                         qseg;
  logic [7:0]                   d;
  logic [7:0]                   c;

  assign pbytes   = cfg.prefix_words;
  assign eff_len  = (cfg.prefix_length > PMAX) ? PMAX : cfg.prefix_length;
  assign want     = pbytes[pos_r];
  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  always_comb begin
    ph    = phase_r;
    pos   = pos_r;
    pds   = pds_r;
    phn   = phn_r;
    slen  = slen_r;
    h0    = held0_r;
    h1    = held1_r;
    st    = started_r;
    nb    = '0;
    bb    = '0;
    dec_v = 1'b0;
    qseg  = 1'b0;
    d     = '0;
    c     = in_url_byte;

    // raw byte
    if (in_byte_present) begin
      if (is_bad(c)) begin
        ph = PH_REJECT;
      end else begin
        case (ph)
          PH_PREFIX: begin
            if (pos < eff_len) begin
              if (c == C_QMARK || c != want) ph = PH_REJECT;
              else pos = pos + 6'd1;
            end else if (c == C_SLASH) begin
              ph = PH_PATH;
            end else if (c == C_QMARK) begin
              ph = PH_QUERY;
            end else begin
              ph = PH_REJECT;
            end
          end
          PH_PATH: begin
            if (pds == 2'd0) begin
              if (c == C_PCT) pds = 2'd1;
              else if (c == C_QMARK) qseg = 1'b1;
              else begin
                dec_v = 1'b1;
                d = c;
              end
            end else if (!hex_ok(c)) begin
              ph = PH_REJECT;
            end else if (pds == 2'd1) begin
              phn = hex_val(c);
              pds = 2'd2;
            end else begin
              pds = 2'd0;
              dec_v = 1'b1;
              d = {phn, hex_val(c)};
            end
          end
          default: begin
          end
        endcase
      end
    end

    // decoded byte
    if (dec_v) begin
      if (is_bad(d)) begin
        ph = PH_REJECT;
      end else if (d == C_SLASH) begin
        qseg = 1'b1;
      end else if (slen == 2'd3) begin
        bb[nb[1:0]] = d;
        nb = nb + 3'd1;
      end else if (slen < 2'd2) begin
        if (slen == 2'd0) h0 = d;
        else h1 = d;
        slen = slen + 2'd1;
      end else begin
        if (st) begin
          bb[nb[1:0]] = C_SLASH;
          nb = nb + 3'd1;
        end
        st = 1'b1;
        bb[nb[1:0]] = h0;
        nb = nb + 3'd1;
        bb[nb[1:0]] = h1;
        nb = nb + 3'd1;
        bb[nb[1:0]] = d;
        nb = nb + 3'd1;
        slen = 2'd3;
      end
    end

    // segment end from separator or query mark
    if (qseg) begin
      if (slen == 2'd1) begin
        if (h0 != C_DOT) begin
          if (st) begin
            bb[nb[1:0]] = C_SLASH;
            nb = nb + 3'd1;
          end
          st = 1'b1;
          bb[nb[1:0]] = h0;
          nb = nb + 3'd1;
        end
      end else if (slen == 2'd2) begin
        if (h0 == C_DOT && h1 == C_DOT) begin
          ph = PH_REJECT;
        end else begin
          if (st) begin
            bb[nb[1:0]] = C_SLASH;
            nb = nb + 3'd1;
          end
          st = 1'b1;
          bb[nb[1:0]] = h0;
          nb = nb + 3'd1;
          bb[nb[1:0]] = h1;
          nb = nb + 3'd1;
        end
      end
      slen = 2'd0;
      if (in_byte_present && c == C_QMARK && ph == PH_PATH) ph = PH_QUERY;
    end

    // end of url
    if (in_final_byte) begin
      if (ph == PH_PREFIX) begin
        if (pos < eff_len) ph = PH_REJECT;
      end else if (ph == PH_PATH) begin
        if (pds != 2'd0) begin
          ph = PH_REJECT;
        end else if (slen == 2'd1) begin
          if (h0 != C_DOT) begin
            if (st) begin
              bb[nb[1:0]] = C_SLASH;
              nb = nb + 3'd1;
            end
            st = 1'b1;
            bb[nb[1:0]] = h0;
            nb = nb + 3'd1;
          end
        end else if (slen == 2'd2) begin
          if (h0 == C_DOT && h1 == C_DOT) begin
            ph = PH_REJECT;
          end else begin
            if (st) begin
              bb[nb[1:0]] = C_SLASH;
              nb = nb + 3'd1;
            end
            st = 1'b1;
            bb[nb[1:0]] = h0;
            nb = nb + 3'd1;
            bb[nb[1:0]] = h1;
            nb = nb + 3'd1;
          end
        end
      end
    end

    push               = accept && (nb != 3'd0 || in_final_byte);
    push_data.nbytes   = nb;
    push_data.bytes    = bb;
    push_data.has_end  = in_final_byte;
    push_data.rejected = in_final_byte && (ph == PH_REJECT);

    held0_nxt = h0;
    held1_nxt = h1;
    if (in_final_byte) begin
      phase_nxt   = PH_PREFIX;
      pos_nxt     = '0;
      pds_nxt     = '0;
      phn_nxt     = '0;
      slen_nxt    = '0;
      started_nxt = 1'b0;
    end else begin
      phase_nxt   = ph;
      pos_nxt     = pos;
      pds_nxt     = pds;
      phn_nxt     = phn;
      slen_nxt    = slen;
      started_nxt = st;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_PREFIX;
      pos_r     <= '0;
      pds_r     <= '0;
      phn_r     <= '0;
      slen_r    <= '0;
      started_r <= 1'b0;
    end else if (accept) begin
      phase_r   <= phase_nxt;
      pos_r     <= pos_nxt;
      pds_r     <= pds_nxt;
      phn_r     <= phn_nxt;
      slen_r    <= slen_nxt;
      started_r <= started_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      held0_r <= held0_nxt;
      held1_r <= held1_nxt;
    end
  end

endmodule
`default_nettype wire

@@ rtl/upn_queue.sv @@
`default_nettype none
module upn_queue import upn_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  bundle_t push_data,
  input  logic    pop,
  output bundle_t head,
  output logic    empty,
  output logic    full
);

  localparam int PW = $clog2(QUEUE_DEPTH);

  bundle_t          slots_r [QUEUE_DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [PW:0]      count_r, count_nxt;

  assign empty = (count_r == '0);
  assign full  = (count_r == (PW+1)'(QUEUE_DEPTH));
  assign head  = slots_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) wr_ptr_nxt = wr_ptr_r + 1'b1;
    if (pop) rd_ptr_nxt = rd_ptr_r + 1'b1;
    if (push && !pop) count_nxt = count_r + 1'b1;
    else if (pop && !push) count_nxt = count_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) slots_r[wr_ptr_r] <= push_data;
  end

endmodule
`default_nettype wire

@@ rtl/upn_back.sv @@
`default_nettype none
module upn_back import upn_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  bundle_t    head,
  input  logic       empty,
  output logic       pop,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_path_byte,
  output logic       out_path_byte_valid,
  output logic       out_end_of_result,
  output logic       out_rejected
);

  logic [2:0] idx_r, idx_nxt;
  logic       valid_r;
  logic [7:0] byte_r, byte_nxt;
  logic       bvalid_r, bvalid_nxt;
  logic       end_r, end_nxt;
  logic       rej_r, rej_nxt;
  logic       load;
  logic       last;
  logic [2:0] total;

  assign load  = !empty && (!valid_r || out_ready);
  assign total = head.nbytes + {2'b00, head.has_end};
  assign last  = (idx_r + 3'd1 == total);
  assign pop   = load && last;

  always_comb begin
    idx_nxt = idx_r;
    if (load) idx_nxt = last ? 3'd0 : idx_r + 3'd1;
    if (idx_r < head.nbytes) begin
      byte_nxt   = head.bytes[idx_r[1:0]];
      bvalid_nxt = 1'b1;
      end_nxt    = 1'b0;
      rej_nxt    = 1'b0;
    end else begin
      byte_nxt   = '0;
      bvalid_nxt = 1'b0;
      end_nxt    = 1'b1;
      rej_nxt    = head.rejected;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r   <= '0;
      valid_r <= 1'b0;
    end else begin
      idx_r <= idx_nxt;
      if (load) valid_r <= 1'b1;
      else if (out_ready) valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      byte_r   <= byte_nxt;
      bvalid_r <= bvalid_nxt;
      end_r    <= end_nxt;
      rej_r    <= rej_nxt;
    end
  end

  assign out_valid           = valid_r;
  assign out_path_byte       = byte_r;
  assign out_path_byte_valid = bvalid_r;
  assign out_end_of_result   = end_r;
  assign out_rejected        = rej_r;

endmodule
`default_nettype wire

@@ rtl/url_path_normalizer_top.sv @@
// channel   | handshake           | payload
// ----------+---------------------+--------------------------------------------
// input     | in_valid/in_ready   | in_url_byte, in_byte_present, in_final_byte
// result    | out_valid/out_ready | out_path_byte, out_path_byte_valid,
//           |                     | out_end_of_result, out_rejected
// config    | psel/penable/pwrite | paddr, pwdata, prdata, pready
//
// one url byte is taken per cycle while the 4-entry bundle queue has room
// each byte yields 0 to 5 items, sent from the queue head one per cycle while out_ready is high
// the first item of a bundle passes through a queue slot and then the output register
// a stalled output fills the queue, then in_ready drops; no clearing pass
// rst_n is synchronous, active low, and clears control state; data registers are not cleared
`default_nettype none
module url_path_normalizer_top import upn_pkg::*; #(
  parameter int PREFIX_MAX = PREFIX_MAX_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        in_url_byte,
  input  logic              in_byte_present,
  input  logic              in_final_byte,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [7:0]        out_path_byte,
  output logic              out_path_byte_valid,
  output logic              out_end_of_result,
  output logic              out_rejected,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic              pready
);

  cfg_t    cfg;
  logic    push;
  bundle_t push_data;
  logic    pop;
  bundle_t head;
  logic    empty;
  logic    full;

  upn_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  upn_front #(.PREFIX_MAX(PREFIX_MAX)) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg             (cfg),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_url_byte     (in_url_byte),
    .in_byte_present (in_byte_present),
    .in_final_byte   (in_final_byte),
    .q_full          (full),
    .push            (push),
    .push_data       (push_data)
  );

  upn_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .empty     (empty),
    .full      (full)
  );

  upn_back u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .head                (head),
    .empty               (empty),
    .pop                 (pop),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_path_byte       (out_path_byte),
    .out_path_byte_valid (out_path_byte_valid),
    .out_end_of_result   (out_end_of_result),
    .out_rejected        (out_rejected)
  );

endmodule
`default_nettype wire

@@ rtl/upn_checker.sv @@
`default_nettype none
module upn_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_path_byte,
  input logic       out_path_byte_valid,
  input logic       out_end_of_result,
  input logic       out_rejected,
  input logic       pready
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_path_byte) &&
      $stable(out_path_byte_valid) && $stable(out_end_of_result) && $stable(out_rejected))
    else $error("result changed while stalled");

  // status item carries no byte
  a_status_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_path_byte_valid |-> out_end_of_result && out_path_byte == 8'h00)
    else $error("malformed status item");

  // byte item carries no status
  a_byte_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_path_byte_valid |-> !out_end_of_result && !out_rejected)
    else $error("byte item flagged as status");

  // normalized bytes never hold control, del or backslash
  a_byte_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_path_byte_valid |->
      out_path_byte >= 8'h20 && out_path_byte != 8'h7F && out_path_byte != 8'h5C)
    else $error("forbidden byte in normalized path");

  a_pready: assert property (@(posedge clk) disable iff (!rst_n) pready)
    else $error("config port not ready");

endmodule

bind url_path_normalizer_top upn_checker u_chk (.*);
`default_nettype wire

@@ tb/url_path_normalizer_top_tb.sv @@
`timescale 1ns / 100ps
module url_path_normalizer_top_tb import upn_pkg::*;;

  localparam int QUIET_LIMIT = 3000;
  localparam int HOLD_CYCLES = 300;
  localparam int ROUND_ITEMS = 52;

  typedef struct packed {
    logic [7:0] path_byte;
    logic       path_byte_valid;
    logic       end_of_result;
    logic       rejected;
  } path_item_t;

  class path_scoreboard;
    logic [5:0]  match_len;
    logic [63:0] match_words [PREFIX_WORDS];
    phase_t      url_phase;
    int unsigned match_pos;
    int unsigned escape_digits;
    logic [3:0]  escape_high;
    int unsigned seg_fill;
    logic [7:0]  seg_head [2];
    bit          path_open;
    path_item_t  expected_path_q[$];
    int          failures;

    function new();
      match_len = '0;
      foreach (match_words[w]) match_words[w] = '0;
      seg_head[0] = '0;
      seg_head[1] = '0;
      failures = 0;
      clear_url();
    endfunction

    function void clear_url();
      url_phase = PH_PREFIX;
      match_pos = 0;
      escape_digits = 0;
      escape_high = '0;
      seg_fill = 0;
      path_open = 1'b0;
    endfunction

    function void write_register(logic [2:0] idx, logic [63:0] value);
      if (idx == REG_PREFIX_LENGTH) match_len = value[5:0];
      else if (idx >= REG_PREFIX_WORD_0 && idx <= REG_PREFIX_WORD_5)
        match_words[idx - REG_PREFIX_WORD_0] = value;
    endfunction

    function int unsigned effective_len();
      return (match_len > PREFIX_BYTES) ? PREFIX_BYTES : match_len;
    endfunction

    function logic [7:0] prefix_byte(int unsigned k);
      return match_words[k >> 3][(k & 7) * 8 +: 8];
    endfunction

    function int open_count();
      return expected_path_q.size();
    endfunction

    function void expect_item(logic [7:0] b, bit v, bit e, bit r);
      path_item_t item;
      item.path_byte = b;
      item.path_byte_valid = v;
      item.end_of_result = e;
      item.rejected = r;
      expected_path_q.insert(expected_path_q.size(), item);
    endfunction

    function bit forbidden(logic [7:0] c);
      return c == "\\" || c < 8'h20 || c == 8'h7f;
    endfunction

    function void put_slash();
      if (path_open) expect_item("/", 1'b1, 1'b0, 1'b0);
      path_open = 1'b1;
    endfunction

    function void seg_push(logic [7:0] c);
      if (seg_fill >= 3) begin
        expect_item(c, 1'b1, 1'b0, 1'b0);
      end else if (seg_fill < 2) begin
        seg_head[seg_fill] = c;
        seg_fill++;
      end else begin
        put_slash();
        expect_item(seg_head[0], 1'b1, 1'b0, 1'b0);
        expect_item(seg_head[1], 1'b1, 1'b0, 1'b0);
        expect_item(c, 1'b1, 1'b0, 1'b0);
        seg_fill = 3;
      end
    endfunction

    function void seg_close();
      if (seg_fill == 1) begin
        if (seg_head[0] != ".") begin
          put_slash();
          expect_item(seg_head[0], 1'b1, 1'b0, 1'b0);
        end
      end else if (seg_fill == 2) begin
        if (seg_head[0] == "." && seg_head[1] == ".") begin
          url_phase = PH_REJECT;
        end else begin
          put_slash();
          expect_item(seg_head[0], 1'b1, 1'b0, 1'b0);
          expect_item(seg_head[1], 1'b1, 1'b0, 1'b0);
        end
      end
      seg_fill = 0;
    endfunction

    function void take_decoded(logic [7:0] d);
      if (forbidden(d)) url_phase = PH_REJECT;
      else if (d == "/") seg_close();
      else seg_push(d);
    endfunction

    function void feed_byte(logic [7:0] c);
      int nib;
      if (forbidden(c)) begin
        url_phase = PH_REJECT;
        return;
      end
      case (url_phase)
        PH_PREFIX: begin
          if (match_pos < effective_len()) begin
            if (c == "?" || c != prefix_byte(match_pos)) url_phase = PH_REJECT;
            else match_pos++;
          end else if (c == "/") begin
            url_phase = PH_PATH;
          end else if (c == "?") begin
            url_phase = PH_QUERY;
          end else begin
            url_phase = PH_REJECT;
          end
        end
        PH_PATH: begin
          if (escape_digits == 0) begin
            if (c == "%") begin
              escape_digits = 1;
            end else if (c == "?") begin
              seg_close();
              if (url_phase == PH_PATH) url_phase = PH_QUERY;
            end else begin
              take_decoded(c);
            end
          end else begin
            if (c >= "0" && c <= "9") nib = c - "0";
            else if (c >= "a" && c <= "f") nib = c - "a" + 10;
            else if (c >= "A" && c <= "F") nib = c - "A" + 10;
            else nib = -1;
            if (nib < 0) begin
              url_phase = PH_REJECT;
            end else if (escape_digits == 1) begin
              escape_high = nib[3:0];
              escape_digits = 2;
            end else begin
              escape_digits = 0;
              take_decoded({escape_high, nib[3:0]});
            end
          end
        end
        default: ;
      endcase
    endfunction

    function void note_request(logic [7:0] b, bit present, bit fin);
      if (present) feed_byte(b);
      if (fin) begin
        if (url_phase == PH_PREFIX) begin
          if (match_pos < effective_len()) url_phase = PH_REJECT;
        end else if (url_phase == PH_PATH) begin
          if (escape_digits != 0) url_phase = PH_REJECT;
          else seg_close();
        end
        expect_item(8'h00, 1'b0, 1'b1, url_phase == PH_REJECT);
        clear_url();
      end
    endfunction

    function void check_result(path_item_t got);
      path_item_t want;
      if (expected_path_q.size() == 0) begin
        $error("unexpected result: path_byte %02h valid %0b end %0b rejected %0b",
               got.path_byte, got.path_byte_valid, got.end_of_result, got.rejected);
        failures++;
        return;
      end
      want = expected_path_q.pop_front();
      if (got.path_byte !== want.path_byte) begin
        $error("path_byte expected %02h actual %02h", want.path_byte, got.path_byte);
        failures++;
      end
      if (got.path_byte_valid !== want.path_byte_valid) begin
        $error("path_byte_valid expected %0b actual %0b",
               want.path_byte_valid, got.path_byte_valid);
        failures++;
      end
      if (got.end_of_result !== want.end_of_result) begin
        $error("end_of_result expected %0b actual %0b", want.end_of_result, got.end_of_result);
        failures++;
      end
      if (got.rejected !== want.rejected) begin
        $error("rejected expected %0b actual %0b", want.rejected, got.rejected);
        failures++;
      end
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [7:0]        in_url_byte = '0;
  logic              in_byte_present = 1'b0;
  logic              in_final_byte = 1'b0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [7:0]        out_path_byte;
  logic              out_path_byte_valid;
  logic              out_end_of_result;
  logic              out_rejected;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [CFG_AW-1:0] paddr = '0;
  logic [CFG_DW-1:0] pwdata = '0;
  logic [CFG_DW-1:0] prdata;
  logic              pready;

  path_scoreboard sb = new();
  logic [63:0]    word_plan [PREFIX_WORDS];
  int             tx_idle_pct = 0;
  int             rx_stall_pct = 0;
  int             rx_hold_asked = 0;
  int             rx_hold_done = 0;
  int             rx_hold_left = 0;
  int             quiet_cycles = 0;
  int             items_sent = 0;

  url_path_normalizer_top dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_url_byte         (in_url_byte),
    .in_byte_present     (in_byte_present),
    .in_final_byte       (in_final_byte),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_path_byte       (out_path_byte),
    .out_path_byte_valid (out_path_byte_valid),
    .out_end_of_result   (out_end_of_result),
    .out_rejected        (out_rejected),
    .psel                (psel),
    .penable             (penable),
    .pwrite              (pwrite),
    .paddr               (paddr),
    .pwdata              (pwdata),
    .prdata              (prdata),
    .pready              (pready)
  );

  always #5 clk = ~clk;

  // receiver: random stalls, plus a long hold-off when asked
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (rx_hold_left > 0) begin
      out_ready <= 1'b0;
      rx_hold_left <= rx_hold_left - 1;
    end else if (rx_hold_asked != rx_hold_done) begin
      out_ready <= 1'b0;
      rx_hold_done <= rx_hold_asked;
      rx_hold_left <= HOLD_CYCLES;
    end else begin
      out_ready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready)
        sb.check_result({out_path_byte, out_path_byte_valid, out_end_of_result, out_rejected});
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  function automatic logic [7:0] plain_byte();
    logic [7:0] c;
    do c = 8'($urandom_range(8'h21, 8'h7e));
    while (c == "%" || c == "?" || c == "/" || c == "\\");
    return c;
  endfunction

  function automatic logic [7:0] bad_byte();
    int unsigned r;
    r = $urandom_range(33);
    if (r < 32) return 8'(r);
    return (r == 32) ? 8'h7f : "\\";
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] n);
    logic [7:0] base;
    if (n < 10) return 8'("0" + n);
    base = $urandom_range(1) ? "a" : "A";
    return 8'(base + n - 10);
  endfunction

  task automatic send_item(input logic [7:0] b, input logic present, input logic fin);
    if ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < tx_idle_pct);
    end
    in_valid <= 1'b1;
    in_url_byte <= b;
    in_byte_present <= present;
    in_final_byte <= fin;
    do @(posedge clk); while (!in_ready);
    sb.note_request(b, present, fin);
    if (present || fin) items_sent++;
  endtask

  task automatic send_text(input string t, input bit close);
    int i;
    for (i = 0; i < t.len(); i++) send_item(t[i], 1'b1, close && i == t.len() - 1);
  endtask

  task automatic send_url();
    logic [7:0]  url_q[$];
    logic [7:0]  code;
    int unsigned roll, pick, plen, k, s;
    roll = $urandom_range(99);
    if (roll < 8) begin
      // noise
      repeat ($urandom_range(1, 8)) send_item(8'($urandom), 1'($urandom), 1'($urandom));
      send_item(8'($urandom), 1'($urandom), 1'b1);
      return;
    end
    plen = sb.effective_len();
    for (k = 0; k < plen; k++) url_q.insert(url_q.size(), sb.prefix_byte(k));
    if (roll < 14 && plen > 0) url_q[$urandom_range(plen - 1)] = 8'($urandom);
    pick = $urandom_range(99);
    if (pick < 4) url_q.insert(url_q.size(), "?");
    else if (pick < 8) url_q.insert(url_q.size(), plain_byte());
    else if (pick >= 12) url_q.insert(url_q.size(), "/");
    if (pick < 8 || pick >= 12) begin
      for (s = 0; s < $urandom_range(0, 4); s++) begin
        if (s > 0) begin
          url_q.insert(url_q.size(), "/");
          if ($urandom_range(9) == 0) url_q.insert(url_q.size(), "/");
        end
        pick = $urandom_range(99);
        if (pick < 8) begin
          url_q.insert(url_q.size(), ".");
        end else if (pick < 12) begin
          url_q.insert(url_q.size(), ".");
          url_q.insert(url_q.size(), ".");
        end else if (pick >= 16) begin
          repeat ($urandom_range(1, 5)) begin
            pick = $urandom_range(99);
            if (pick < 65) begin
              url_q.insert(url_q.size(), plain_byte());
            end else if (pick < 78) begin
              url_q.insert(url_q.size(), 8'($urandom_range(8'h80, 8'hff)));
            end else if (pick < 96) begin
              k = $urandom_range(9);
              if (k == 0) code = "/";
              else if (k == 1) code = ".";
              else if (k == 2) code = 8'($urandom);
              else code = plain_byte();
              url_q.insert(url_q.size(), "%");
              url_q.insert(url_q.size(), hex_char(code[7:4]));
              url_q.insert(url_q.size(), hex_char(code[3:0]));
            end else begin
              url_q.insert(url_q.size(), "%");
              if ($urandom_range(1)) url_q.insert(url_q.size(), hex_char(4'($urandom)));
              url_q.insert(url_q.size(), "G");
            end
          end
        end
      end
      if ($urandom_range(3) == 0) url_q.insert(url_q.size(), "/");
      if ($urandom_range(4) == 0) begin
        url_q.insert(url_q.size(), "?");
        repeat ($urandom_range(0, 4))
          url_q.insert(url_q.size(), ($urandom_range(15) == 0) ? bad_byte()
                                       : 8'($urandom_range(8'h20, 8'hff)));
      end
    end
    if ($urandom_range(24) == 0 && url_q.size() > 0)
      url_q[$urandom_range(url_q.size() - 1)] = bad_byte();
    if (roll >= 14 && roll < 20 && plen > 0) begin
      // cut inside the prefix
      k = $urandom_range(plen - 1);
      while (url_q.size() > k) void'(url_q.pop_back());
    end
    if (url_q.size() == 0 || $urandom_range(3) == 0) begin
      foreach (url_q[i]) send_item(url_q[i], 1'b1, 1'b0);
      send_item(8'($urandom), 1'b0, 1'b1);
    end else begin
      foreach (url_q[i]) send_item(url_q[i], 1'b1, i == url_q.size() - 1);
    end
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [63:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 3'b000};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.write_register(idx, value);
  endtask

  task automatic load_prefix(input logic [5:0] len);
    int w;
    write_reg(REG_PREFIX_LENGTH, 64'(len));
    for (w = 0; w < PREFIX_WORDS; w++) write_reg(3'(REG_PREFIX_WORD_0 + w), word_plan[w]);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.open_count() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_regime(input int regime);
    case (regime)
      0: begin
        tx_idle_pct = 8;
        rx_stall_pct <= 51;
      end
      1: begin
        tx_idle_pct = 51;
        rx_stall_pct <= 8;
      end
      default: begin
        tx_idle_pct = 0;
        rx_stall_pct <= 0;
      end
    endcase
  endtask

  initial begin
    int         round, k, goal;
    logic [5:0] len;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    set_regime(0);

    // prefix "a"
    foreach (word_plan[w]) word_plan[w] = '0;
    word_plan[0] = 64'h61;
    load_prefix(6'd1);
    send_item(8'hff, 1'b0, 1'b1);
    send_item("?", 1'b1, 1'b1);
    send_text("az", 1'b1);
    send_item(8'h00, 1'b0, 1'b0);
    send_text("a/x..%2F./ab%4?", 1'b1);
    send_text("a?", 1'b0);
    send_item(8'h7f, 1'b1, 1'b1);
    send_item(8'h00, 1'b1, 1'b1);
    drain();

    for (round = 0; round < 6; round++) begin
      set_regime(round / 2);
      case (round)
        1: begin
          len = 6'd48;
          foreach (word_plan[w]) word_plan[w] = '1;
        end
        2: begin
          len = 6'd0;
          foreach (word_plan[w]) word_plan[w] = {$urandom, $urandom};
        end
        default: begin
          if (round == 3) len = 6'd63;
          else if (round == 0) len = 6'($urandom_range(1, 12));
          else len = 6'($urandom_range(1, 6));
          foreach (word_plan[w])
            for (k = 0; k < 8; k++) word_plan[w][8 * k +: 8] = plain_byte();
        end
      endcase
      load_prefix(len);
      if (round == 1) rx_hold_asked <= rx_hold_asked + 1;
      goal = items_sent + ROUND_ITEMS;
      while (items_sent < goal) send_url();
      send_item(8'h00, 1'b0, 1'b1);
      drain();
    end

    if (sb.failures == 0 && sb.open_count() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
